// ===== rtl/core/plb_pkg.sv =====
// shared types, constants and palette function for the palette line blend scaler
package plb_pkg;

   // field widths
   localparam int INDEX_W  = 2;
   localparam int LINE_W   = 8;
   localparam int COLUMN_W = 8;
   localparam int PIXEL_W  = 16;
   localparam int PORT_W   = 8;
   localparam int WEIGHT_W = 4;
   localparam int CHAN_W   = 6;
   localparam int FACTOR_W = WEIGHT_W + 1;
   localparam int PROD_W   = CHAN_W + FACTOR_W;
   localparam int NUM_CHAN = 3;

   // channel positions in the product arrays
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   // rgb565 channel masks
   localparam logic [PIXEL_W-1:0] RGB_RED   = 16'hF800;
   localparam logic [PIXEL_W-1:0] RGB_GREEN = 16'h07E0;
   localparam logic [PIXEL_W-1:0] RGB_BLUE  = 16'h001F;

   // weight of a source line that is dropped
   localparam logic [WEIGHT_W-1:0] WEIGHT_DROP = 4'hF;
   // full weight, sixteen sixteenths
   localparam logic [FACTOR_W-1:0] WEIGHT_FULL = 5'd16;

   // palette port bit positions
   localparam int PB_BLUE_ALL  = 6;
   localparam int PB_GREEN_ALL = 5;
   localparam int PB_RED_ALL   = 4;
   localparam int PB_IDX0_RED  = 3;
   localparam int PB_IDX0_BLUE = 2;
   localparam int PB_IDX3_GRN  = 1;
   localparam int PB_IDX1_RED  = 0;

   // colour indices
   localparam logic [INDEX_W-1:0] IDX_0 = 2'd0;
   localparam logic [INDEX_W-1:0] IDX_1 = 2'd1;
   localparam logic [INDEX_W-1:0] IDX_2 = 2'd2;
   localparam logic [INDEX_W-1:0] IDX_3 = 2'd3;

   typedef logic [PROD_W-1:0] prod_type;

   // stage one payload: both palette colours and the line weight
   typedef struct packed {
      logic [PIXEL_W-1:0]  colour_a;
      logic [PIXEL_W-1:0]  colour_b;
      logic [WEIGHT_W-1:0] weight;
      logic [LINE_W-1:0]   row;
      logic [COLUMN_W-1:0] column;
   } s1_type;

   // stage two payload: weighted channel products
   typedef struct packed {
      prod_type [NUM_CHAN-1:0] prod_a;
      prod_type [NUM_CHAN-1:0] prod_b;
      logic [LINE_W-1:0]       row;
      logic [COLUMN_W-1:0]     column;
   } s2_type;

   // four-colour palette derived from the palette select byte
   function automatic logic [PIXEL_W-1:0] palette_colour(
      input logic [PORT_W-1:0]  port,
      input logic [INDEX_W-1:0] idx
   );
      logic [PIXEL_W-1:0] c;
      c = '0;
      if (port[PB_BLUE_ALL])  c = c ^ RGB_BLUE;
      if (port[PB_GREEN_ALL]) c = c ^ RGB_GREEN;
      if (port[PB_RED_ALL])   c = c ^ RGB_RED;
      case (idx)
         IDX_0: begin
            if (!port[PB_IDX0_RED])  c = c ^ RGB_RED;
            if (!port[PB_IDX0_BLUE]) c = c ^ RGB_BLUE;
         end
         IDX_1: begin
            c = c ^ RGB_BLUE;
            if (!port[PB_IDX1_RED]) c = c ^ RGB_RED;
         end
         IDX_2: begin
            c = c ^ RGB_GREEN;
         end
         default: begin
            c = c ^ RGB_RED;
            if (!port[PB_IDX3_GRN]) c = c ^ RGB_GREEN;
         end
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/core/plb_ifs.sv =====
// channel interfaces of the palette line blend scaler

// pixel pair request channel
interface plb_req_if;
   logic                             valid;
   logic                             ready;
   logic [plb_pkg::INDEX_W-1:0]      upper_index;
   logic [plb_pkg::INDEX_W-1:0]      lower_index;
   logic [plb_pkg::LINE_W-1:0]       source_line;
   logic [plb_pkg::COLUMN_W-1:0]     column;

   modport source (output valid, upper_index, lower_index, source_line, column,
                   input ready);
   modport sink   (input valid, upper_index, lower_index, source_line, column,
                   output ready);
endinterface

// blended pixel response channel
interface plb_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [plb_pkg::LINE_W-1:0]       out_row;
   logic [plb_pkg::COLUMN_W-1:0]     out_column;
   logic [plb_pkg::PIXEL_W-1:0]      pixel_rgb565;

   modport source (output valid, out_row, out_column, pixel_rgb565, input ready);
   modport sink   (input valid, out_row, out_column, pixel_rgb565, output ready);
endinterface

// palette register write channel
interface plb_csr_if;
   logic                             valid;
   logic                             ready;
   logic [plb_pkg::PORT_W-1:0]       data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/palette_line_blend_scaler_top.sv =====
// palette line blend scaler: three-stage pixel pipeline from palette indices to rgb565
//
// Each request transaction carries the 2-bit colour indices of one pixel on source
// lines y and y+1; both are looked up in a four-colour palette set by the palette
// byte written on the csr channel, blended vertically with weight y&15 and sent
// out as rgb565 at row y-(y>>4) and the same column. Source lines with weight 15
// give no response. The pipeline takes one request per clock. Stage one does the palette
// lookup and row calculation, stage two the weighted channel products, stage three the
// sums and repacking into the response register. Back-pressure on the response channel
// stalls the stages in turn; a stage with a gap still moves up, so requests are
// refused only once all three stages hold a transaction and the response waits.
// Palette writes are taken every cycle and apply to requests accepted after them.
module palette_line_blend_scaler_top (
   input  logic         clock,
   input  logic         reset,
   plb_req_if.sink      req_if,
   plb_rsp_if.source    rsp_if,
   plb_csr_if.sink      csr_if
);

   logic [plb_pkg::PORT_W-1:0]   palette_ff;

   logic                         s1_valid_ff, s1_valid_in, s1_ready;
   plb_pkg::s1_type              s1_ff, s1_in;
   logic                         s2_valid_ff, s2_ready;
   plb_pkg::s2_type              s2_ff, s2_in;
   logic                         s3_valid_ff, s3_ready;
   logic [plb_pkg::LINE_W-1:0]   s3_row_ff;
   logic [plb_pkg::COLUMN_W-1:0] s3_column_ff;
   logic [plb_pkg::PIXEL_W-1:0]  s3_pixel_ff, s3_pixel_in;

   logic [plb_pkg::NUM_CHAN-1:0][plb_pkg::CHAN_W-1:0] chan_a, chan_b;
   logic [plb_pkg::FACTOR_W-1:0] factor_a, factor_b;
   logic [plb_pkg::NUM_CHAN-1:0][plb_pkg::CHAN_W-1:0] mix;
   logic [plb_pkg::PROD_W-1:0]   mix_sum;

   // palette register
   assign csr_if.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff <= '0;
      end else if (csr_if.valid && csr_if.ready) begin
         palette_ff <= csr_if.data;
      end
   end

   // stall chain, each stage moves when its successor has room
   assign s3_ready     = !s3_valid_ff || rsp_if.ready;
   assign s2_ready     = !s2_valid_ff || s3_ready;
   assign s1_ready     = !s1_valid_ff || s2_ready;
   assign req_if.ready = s1_ready;

   // stage one: palette lookup, weight and destination row
   always_comb begin
      s1_valid_in     = req_if.valid
                        && (req_if.source_line[plb_pkg::WEIGHT_W-1:0] != plb_pkg::WEIGHT_DROP);
      s1_in.colour_a  = plb_pkg::palette_colour(palette_ff, req_if.upper_index);
      s1_in.colour_b  = plb_pkg::palette_colour(palette_ff, req_if.lower_index);
      s1_in.weight    = req_if.source_line[plb_pkg::WEIGHT_W-1:0];
      s1_in.row       = req_if.source_line
                        - (req_if.source_line >> plb_pkg::WEIGHT_W);
      s1_in.column    = req_if.column;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && s1_valid_in) begin
         s1_ff <= s1_in;
      end
   end

   // stage two: widen channels to six bits and weight them
   always_comb begin
      chan_a[plb_pkg::CH_RED]   = {s1_ff.colour_a[15:11], 1'b0};
      chan_a[plb_pkg::CH_GREEN] = s1_ff.colour_a[10:5];
      chan_a[plb_pkg::CH_BLUE]  = {s1_ff.colour_a[4:0], 1'b0};
      chan_b[plb_pkg::CH_RED]   = {s1_ff.colour_b[15:11], 1'b0};
      chan_b[plb_pkg::CH_GREEN] = s1_ff.colour_b[10:5];
      chan_b[plb_pkg::CH_BLUE]  = {s1_ff.colour_b[4:0], 1'b0};
      factor_b = {1'b0, s1_ff.weight};
      factor_a = plb_pkg::WEIGHT_FULL - factor_b;
      for (int i = 0; i < plb_pkg::NUM_CHAN; i++) begin
         s2_in.prod_a[i] = plb_pkg::PROD_W'(chan_a[i] * factor_a);
         s2_in.prod_b[i] = plb_pkg::PROD_W'(chan_b[i] * factor_b);
      end
      s2_in.row    = s1_ff.row;
      s2_in.column = s1_ff.column;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
   end

   // stage three: sum, divide by sixteen and repack to rgb565
   always_comb begin
      mix_sum = '0;
      for (int i = 0; i < plb_pkg::NUM_CHAN; i++) begin
         mix_sum = s2_ff.prod_a[i] + s2_ff.prod_b[i];
         mix[i]  = mix_sum[plb_pkg::WEIGHT_W +: plb_pkg::CHAN_W];
      end
      s3_pixel_in = {mix[plb_pkg::CH_RED][5:1],
                     mix[plb_pkg::CH_GREEN],
                     mix[plb_pkg::CH_BLUE][5:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_pixel_ff  <= s3_pixel_in;
         s3_row_ff    <= s2_ff.row;
         s3_column_ff <= s2_ff.column;
      end
   end

   // response channel
   assign rsp_if.valid        = s3_valid_ff;
   assign rsp_if.out_row      = s3_row_ff;
   assign rsp_if.out_column   = s3_column_ff;
   assign rsp_if.pixel_rgb565 = s3_pixel_ff;

   // a dropped source line never enters the pipeline
   a_drop_line: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready
       && req_if.source_line[plb_pkg::WEIGHT_W-1:0] == plb_pkg::WEIGHT_DROP)
      |=> !s1_valid_ff)
      else $error("dropped source line entered stage one");

   // a kept source line always enters the pipeline
   a_keep_line: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready
       && req_if.source_line[plb_pkg::WEIGHT_W-1:0] != plb_pkg::WEIGHT_DROP)
      |=> s1_valid_ff)
      else $error("kept source line lost at stage one");

   // a stalled middle stage keeps its transaction
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s3_ready) |=> (s2_valid_ff && $stable(s2_ff)))
      else $error("stage two transaction changed while stalled");

   // destination row stays inside the fifteen-of-sixteen range
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_row_ff <= 8'd239))
      else $error("destination row out of range");

endmodule

// ===== verif/palette_line_blend_scaler_top_tb.sv =====
// self-checking testbench for the palette line blend scaler: directed table then random pixel pairs
module palette_line_blend_scaler_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_OFF_CYCLES = 100;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PHASES          = 12;
   localparam int PHASE_PAIRS     = 162;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int N_DIRECTED      = 20;

   // how a directed row is checked
   typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_DROPPED} row_kind_type;

   typedef struct packed {
      logic [plb_pkg::INDEX_W-1:0]  upper;
      logic [plb_pkg::INDEX_W-1:0]  lower;
      logic [plb_pkg::LINE_W-1:0]   line;
      logic [plb_pkg::COLUMN_W-1:0] column;
   } pixel_pair_type;

   typedef struct packed {
      logic [plb_pkg::LINE_W-1:0]   row;
      logic [plb_pkg::COLUMN_W-1:0] column;
      logic [plb_pkg::PIXEL_W-1:0]  pixel;
   } blended_pixel_type;

   typedef struct packed {
      pixel_pair_type    pair;
      row_kind_type      kind;
      blended_pixel_type typed;
   } pair_row_type;

   // palette 0 after reset: index 0 and 1 magenta, 2 green, 3 yellow
   localparam pair_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{'{plb_pkg::IDX_0, plb_pkg::IDX_3, 8'd0, 8'd0}, ROW_TYPED,
        '{8'd0, 8'd0, 16'hF81F}},
      '{'{plb_pkg::IDX_1, plb_pkg::IDX_0, 8'd0, 8'd255}, ROW_TYPED,
        '{8'd0, 8'd255, 16'hF81F}},
      '{'{plb_pkg::IDX_2, plb_pkg::IDX_1, 8'd16, 8'd1}, ROW_TYPED,
        '{8'd15, 8'd1, 16'h07E0}},
      '{'{plb_pkg::IDX_3, plb_pkg::IDX_2, 8'd240, 8'd128}, ROW_TYPED,
        '{8'd225, 8'd128, 16'hFFE0}},
      '{'{plb_pkg::IDX_0, plb_pkg::IDX_2, 8'd15, 8'd3}, ROW_DROPPED, '0},
      '{'{plb_pkg::IDX_3, plb_pkg::IDX_3, 8'd255, 8'd255}, ROW_DROPPED, '0},
      '{'{plb_pkg::IDX_1, plb_pkg::IDX_2, 8'd239, 8'd7}, ROW_DROPPED, '0},
      '{'{plb_pkg::IDX_2, plb_pkg::IDX_2, 8'd254, 8'd254}, ROW_TYPED,
        '{8'd239, 8'd254, 16'h07E0}},
      '{'{plb_pkg::IDX_3, plb_pkg::IDX_3, 8'd7, 8'd64}, ROW_TYPED,
        '{8'd7, 8'd64, 16'hFFE0}},
      '{'{plb_pkg::IDX_0, plb_pkg::IDX_1, 8'd8, 8'd32}, ROW_TYPED,
        '{8'd8, 8'd32, 16'hF81F}},
      '{'{plb_pkg::IDX_0, plb_pkg::IDX_2, 8'd1, 8'd10}, ROW_PREDICT, '0},
      '{'{plb_pkg::IDX_0, plb_pkg::IDX_2, 8'd8, 8'd11}, ROW_PREDICT, '0},
      '{'{plb_pkg::IDX_0, plb_pkg::IDX_2, 8'd14, 8'd12}, ROW_PREDICT, '0},
      '{'{plb_pkg::IDX_2, plb_pkg::IDX_0, 8'd14, 8'd13}, ROW_PREDICT, '0},
      '{'{plb_pkg::IDX_3, plb_pkg::IDX_1, 8'd9, 8'd14}, ROW_PREDICT, '0},
      '{'{plb_pkg::IDX_1, plb_pkg::IDX_3, 8'd13, 8'd15}, ROW_PREDICT, '0},
      '{'{plb_pkg::IDX_2, plb_pkg::IDX_3, 8'd85, 8'd16}, ROW_PREDICT, '0},
      '{'{plb_pkg::IDX_3, plb_pkg::IDX_0, 8'd170, 8'd170}, ROW_PREDICT, '0},
      '{'{plb_pkg::IDX_1, plb_pkg::IDX_1, 8'd31, 8'd17}, ROW_DROPPED, '0},
      '{'{plb_pkg::IDX_3, plb_pkg::IDX_2, 8'd17, 8'd18}, ROW_PREDICT, '0}
   };

   localparam logic [plb_pkg::PORT_W-1:0] PRESET_PALETTES [6] = '{
      8'hFF, 8'h00, 8'h7F, 8'h80, 8'h55, 8'hAA
   };

   logic clock = 1'b0;
   logic reset;

   plb_req_if req_ch ();
   plb_rsp_if rsp_ch ();
   plb_csr_if csr_ch ();

   blended_pixel_type          expected_pixels [$];
   logic [plb_pkg::PORT_W-1:0] palette_shadow;
   int                         mismatch_count  = 0;
   int                         cycle_count     = 0;
   int                         hold_requests   = 0;
   int                         sender_burst    = 0;

   palette_line_blend_scaler_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // palette colour built channel by channel from the select byte
   function automatic logic [plb_pkg::PIXEL_W-1:0] lut_colour(
      input logic [plb_pkg::PORT_W-1:0]  sel,
      input logic [plb_pkg::INDEX_W-1:0] idx
   );
      logic red, grn, blu;
      red = sel[plb_pkg::PB_RED_ALL];
      grn = sel[plb_pkg::PB_GREEN_ALL];
      blu = sel[plb_pkg::PB_BLUE_ALL];
      case (idx)
         plb_pkg::IDX_0: begin
            red = red ^ ~sel[plb_pkg::PB_IDX0_RED];
            blu = blu ^ ~sel[plb_pkg::PB_IDX0_BLUE];
         end
         plb_pkg::IDX_1: begin
            blu = ~blu;
            red = red ^ ~sel[plb_pkg::PB_IDX1_RED];
         end
         plb_pkg::IDX_2: begin
            grn = ~grn;
         end
         default: begin
            red = ~red;
            grn = grn ^ ~sel[plb_pkg::PB_IDX3_GRN];
         end
      endcase
      return ({plb_pkg::PIXEL_W{red}} & plb_pkg::RGB_RED)
           | ({plb_pkg::PIXEL_W{grn}} & plb_pkg::RGB_GREEN)
           | ({plb_pkg::PIXEL_W{blu}} & plb_pkg::RGB_BLUE);
   endfunction

   // weighted mean of two 6-bit channels in sixteenths
   function automatic logic [plb_pkg::CHAN_W-1:0] blend6(
      input logic [plb_pkg::CHAN_W-1:0]   near,
      input logic [plb_pkg::CHAN_W-1:0]   far,
      input logic [plb_pkg::WEIGHT_W-1:0] w
   );
      logic [10:0] acc;
      acc = 11'(near) * 11'(plb_pkg::WEIGHT_FULL - {1'b0, w}) + 11'(far) * 11'(w);
      return acc[9:4];
   endfunction

   // expected blended pixel, returns 0 for a dropped line
   function automatic bit predict_blend(input logic [plb_pkg::PORT_W-1:0] sel,
                                        input pixel_pair_type p,
                                        output blended_pixel_type res);
      logic [plb_pkg::PIXEL_W-1:0]  ca, cb;
      logic [plb_pkg::CHAN_W-1:0]   red, grn, blu;
      logic [plb_pkg::WEIGHT_W-1:0] w;
      res = '0;
      w   = p.line[plb_pkg::WEIGHT_W-1:0];
      if (w == plb_pkg::WEIGHT_DROP) return 1'b0;
      ca  = lut_colour(sel, p.upper);
      cb  = lut_colour(sel, p.lower);
      red = blend6({ca[15:11], 1'b0}, {cb[15:11], 1'b0}, w);
      grn = blend6(ca[10:5], cb[10:5], w);
      blu = blend6({ca[4:0], 1'b0}, {cb[4:0], 1'b0}, w);
      res.row    = p.line - {4'd0, p.line[7:4]};
      res.column = p.column;
      res.pixel  = {red[5:1], grn, blu[5:1]};
      return 1'b1;
   endfunction

   // random pixel pair, leaning on the weight extremes now and then
   function automatic pixel_pair_type random_pair();
      pixel_pair_type p;
      int             roll;
      p.upper  = plb_pkg::INDEX_W'($urandom_range(0, 3));
      p.lower  = plb_pkg::INDEX_W'($urandom_range(0, 3));
      p.line   = plb_pkg::LINE_W'($urandom_range(0, 255));
      p.column = plb_pkg::COLUMN_W'($urandom_range(0, 255));
      roll     = $urandom_range(0, 9);
      if (roll == 0) p.line[3:0] = plb_pkg::WEIGHT_DROP;
      else if (roll == 1) p.line[3:0] = 4'h0;
      else if (roll == 2) p.line[3:0] = 4'hE;
      return p;
   endfunction

   // sender idle cycles: mostly none, some short, a few long, with bursts
   function automatic int sender_gap();
      int roll;
      if (sender_burst > 0) begin
         sender_burst--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         sender_burst = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // offer one pixel pair and book its expectation when accepted
   task automatic offer_pair(input pixel_pair_type p, input row_kind_type kind,
                             input blended_pixel_type typed);
      int                idle;
      blended_pixel_type want;
      idle = sender_gap();
      repeat (idle) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid       = 1'b1;
      req_ch.upper_index = p.upper;
      req_ch.lower_index = p.lower;
      req_ch.source_line = p.line;
      req_ch.column      = p.column;
      do @(posedge clock); while (!req_ch.ready);
      case (kind)
         ROW_TYPED:   expected_pixels.push_back(typed);
         ROW_DROPPED: ;
         default: begin
            if (predict_blend(palette_shadow, p, want)) expected_pixels.push_back(want);
         end
      endcase
   endtask

   // stop offering and wait for the pipeline to empty
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // palette select byte write transaction
   task automatic write_palette(input logic [plb_pkg::PORT_W-1:0] value);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.data  = value;
      do @(posedge clock); while (!csr_ch.ready);
      palette_shadow = value;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // response side ready: random stalls, calm stretches and ordered long hold-offs
   initial begin : response_ready
      int stall_left;
      int calm_left;
      int holds_done;
      int roll;
      stall_left   = 0;
      calm_left    = 0;
      holds_done   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            stall_left = HOLD_OFF_CYCLES;
            calm_left  = 0;
         end
         if (stall_left == 0 && calm_left == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) calm_left = $urandom_range(20, 80);
            else if (roll < 12) stall_left = $urandom_range(10, 40);
            else if (roll < 35) stall_left = $urandom_range(1, 3);
         end
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
            if (calm_left > 0) calm_left--;
         end
      end
   end

   // compare each response transaction with the oldest expectation
   always @(posedge clock) begin : response_check
      blended_pixel_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected response: row %0d column %0d pixel %04h",
                   rsp_ch.out_row, rsp_ch.out_column, rsp_ch.pixel_rgb565);
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_ch.out_row !== want.row) begin
               $error("out_row expected %0d actual %0d", want.row, rsp_ch.out_row);
               mismatch_count++;
            end
            if (rsp_ch.out_column !== want.column) begin
               $error("out_column expected %0d actual %0d", want.column, rsp_ch.out_column);
               mismatch_count++;
            end
            if (rsp_ch.pixel_rgb565 !== want.pixel) begin
               $error("pixel_rgb565 expected %04h actual %04h", want.pixel,
                      rsp_ch.pixel_rgb565);
               mismatch_count++;
            end
         end
      end
   end

   // run time limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // stimulus: reset, directed table, then palette phases of random pairs
   initial begin : stimulus
      logic [plb_pkg::PORT_W-1:0] setting;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.upper_index = '0;
      req_ch.lower_index = '0;
      req_ch.source_line = '0;
      req_ch.column      = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.data        = '0;
      palette_shadow     = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows on the reset palette
      for (int i = 0; i < N_DIRECTED; i++) begin
         offer_pair(DIRECTED_ROWS[i].pair, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].typed);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         setting = (phase < 6) ? PRESET_PALETTES[phase]
                               : plb_pkg::PORT_W'($urandom_range(0, 255));
         write_palette(setting);
         // long hold-off on the response side while pairs keep coming
         if (phase == 2) begin
            hold_requests++;
            sender_burst = 150;
         end
         for (int n = 0; n < PHASE_PAIRS; n++) begin
            if (phase == 5 && n == PHASE_PAIRS / 2) wait_drained();
            offer_pair(random_pair(), ROW_PREDICT, '0);
         end
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== palette_line_blend_scaler_top.f =====
rtl/core/plb_pkg.sv
rtl/core/plb_ifs.sv
rtl/core/palette_line_blend_scaler_top.sv
verif/palette_line_blend_scaler_top_tb.sv
